FILE: design/textured_span_mapper_defines.svh
// Assertion macros used by the checker file of the textured span mapper.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef TEXTURED_SPAN_MAPPER_DEFINES_SVH
`define TEXTURED_SPAN_MAPPER_DEFINES_SVH

// Checks that the consequent holds whenever the antecedent holds.
`define TSM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tsm_pkg.sv
// Shared types and constants of the textured span mapper.
// No dependencies; imported by the top level, the output queue and the checker.
`default_nettype none

package tsm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE_TEXEL   = 2'd0,
    CMD_WRITE_PALETTE = 2'd1,
    CMD_START_SPAN    = 2'd2,
    CMD_DRAW_PIXEL    = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_U_SIZE_LOG2  = 2'd0;
  localparam logic [1:0] REG_V_SIZE_LOG2  = 2'd1;
  localparam logic [1:0] REG_PALETTED     = 2'd2;
  localparam logic [1:0] REG_ALPHA_TEST   = 2'd3;

  localparam int CFG_DATA_W  = 4;
  localparam int FRAC_BITS   = 16;
  localparam int PAL_ENTRY_W = 8;
  localparam int CMD_W       = 2;
  localparam int ADDR_W      = 14;
  localparam int WORD_W      = 32;
  localparam int PSEL_W      = 3;

  // Input request layout, lowest bit first.
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_WDATA_LSB = IN_ADDR_LSB + ADDR_W;
  localparam int IN_ALPHA_LSB = IN_WDATA_LSB + WORD_W;
  localparam int IN_USTRT_LSB = IN_ALPHA_LSB + 1;
  localparam int IN_VSTRT_LSB = IN_USTRT_LSB + WORD_W;
  localparam int IN_USTEP_LSB = IN_VSTRT_LSB + WORD_W;
  localparam int IN_VSTEP_LSB = IN_USTEP_LSB + WORD_W;
  localparam int IN_PSEL_LSB  = IN_VSTEP_LSB + WORD_W;
  localparam int IN_USED_W    = IN_PSEL_LSB + PSEL_W;
  localparam int IN_W         = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_FIFO_DEPTH = 4;

endpackage

`default_nettype wire

FILE: design/textured_span_mapper.sv
// Top level of the affine textured span mapper with power-of-two wrapping.
// Depends on tsm_pkg, tsm_ram and tsm_out_fifo.
//
// Requests arrive on the s_axis channel; tuser carries the command and tdata
// the operands. Texel and palette writes go straight into their RAMs; a span
// start loads the U/V coordinates, steps and palette; each draw request yields
// one pixel on the m_axis channel. Other commands produce no output.
// A draw request passes through the texel RAM read, then the palette RAM read
// with the colour select behind it, and is then pushed into the output queue;
// it is visible on m_axis from then on. Throughput is one request per cycle
// while s_axis_tready is high, set by the U/V accumulate and the one read
// port on each RAM.
// The four-entry output queue absorbs receiver stalls: s_axis_tready drops
// only when queued plus in-flight pixels would fill it, so an accepted draw
// always has room. Reset clears the coordinates, the pipeline and the queue
// and restores the default configuration; the RAMs are not cleared and must
// be written before they are read.
`default_nettype none

module textured_span_mapper
  import tsm_pkg::*;
#(
  parameter int TEX_ADDR_BITS = 14,
  parameter int NUM_PALETTES  = 8,
  parameter int COLOR_BITS    = 32,
  localparam int OUT_W = ((COLOR_BITS + ADDR_W + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // address, write_data, write_alpha, u_start, v_start, u_step, v_step,
  // palette_select, zero padding
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  // command
  input  wire logic [CMD_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // pixel_color, texel_address, zero padding
  output logic      [OUT_W-1:0]      m_axis_tdata,
  // pixel_write
  output logic      [0:0]            m_axis_tuser
);

  localparam int PAL_W     = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
  localparam int PAL_DEPTH = NUM_PALETTES * (1 << PAL_ENTRY_W);
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int TEX_DEPTH = 1 << TEX_ADDR_BITS;
  localparam int ENTRY_W   = COLOR_BITS + 1 + ADDR_W;
  localparam int LVL_W     = $clog2(OUT_FIFO_DEPTH + 1);

  function automatic logic [PAL_W-1:0] pal_reduce(logic [PSEL_W-1:0] sel);
    logic [4:0] r;
    r = 5'(sel);
    for (int i = 0; i < (1 << PSEL_W); i++) begin
      if (32'(r) >= NUM_PALETTES) begin
        r = r - 5'(NUM_PALETTES);
      end
    end
    return PAL_W'(r);
  endfunction

  // Configuration registers.
  logic [3:0] u_size_q, v_size_q;
  logic       paletted_q, alpha_test_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_size_q     <= 4'd7;
      v_size_q     <= 4'd7;
      paletted_q   <= 1'b0;
      alpha_test_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_U_SIZE_LOG2: u_size_q     <= cfg_data_i[3:0];
        REG_V_SIZE_LOG2: v_size_q     <= cfg_data_i[3:0];
        REG_PALETTED:    paletted_q   <= cfg_data_i[0];
        REG_ALPHA_TEST:  alpha_test_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Request fields.
  cmd_e              cmd;
  logic [ADDR_W-1:0] in_addr;
  logic [WORD_W-1:0] in_wdata;
  logic              in_alpha;
  logic [WORD_W-1:0] in_u_start, in_v_start, in_u_step, in_v_step;
  logic [PSEL_W-1:0] in_psel;
  logic              accept;

  assign cmd        = cmd_e'(s_axis_tuser);
  assign in_addr    = s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
  assign in_wdata   = s_axis_tdata[IN_WDATA_LSB +: WORD_W];
  assign in_alpha   = s_axis_tdata[IN_ALPHA_LSB];
  assign in_u_start = s_axis_tdata[IN_USTRT_LSB +: WORD_W];
  assign in_v_start = s_axis_tdata[IN_VSTRT_LSB +: WORD_W];
  assign in_u_step  = s_axis_tdata[IN_USTEP_LSB +: WORD_W];
  assign in_v_step  = s_axis_tdata[IN_VSTEP_LSB +: WORD_W];
  assign in_psel    = s_axis_tdata[IN_PSEL_LSB +: PSEL_W];
  assign accept     = s_axis_tvalid & s_axis_tready;

  // Span state.
  logic [WORD_W-1:0] u_q, u_d, v_q, v_d, u_inc_q, u_inc_d, v_inc_q, v_inc_d;
  logic [PAL_W-1:0]  pal_q, pal_d;

  always_comb begin
    u_d     = u_q;
    v_d     = v_q;
    u_inc_d = u_inc_q;
    v_inc_d = v_inc_q;
    pal_d   = pal_q;
    if (accept) begin
      unique case (cmd) inside
        CMD_START_SPAN: begin
          u_d     = in_u_start;
          v_d     = in_v_start;
          u_inc_d = in_u_step;
          v_inc_d = in_v_step;
          pal_d   = pal_reduce(in_psel);
        end
        CMD_DRAW_PIXEL: begin
          u_d = u_q + u_inc_q;
          v_d = v_q + v_inc_q;
        end
        CMD_WRITE_TEXEL, CMD_WRITE_PALETTE: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q     <= '0;
      v_q     <= '0;
      u_inc_q <= '0;
      v_inc_q <= '0;
      pal_q   <= '0;
    end else begin
      u_q     <= u_d;
      v_q     <= v_d;
      u_inc_q <= u_inc_d;
      v_inc_q <= v_inc_d;
      pal_q   <= pal_d;
    end
  end

  // Wrapped texel address from the integer parts of U and V.
  logic [FRAC_BITS-1:0]     u_int, v_int, u_mask, v_mask;
  logic [WORD_W-1:0]        addr_full, addr_wrapped, waddr_ext;
  logic [TEX_ADDR_BITS-1:0] tex_raddr, tex_waddr;

  always_comb begin
    u_int        = u_q[WORD_W-1 -: FRAC_BITS];
    v_int        = v_q[WORD_W-1 -: FRAC_BITS];
    u_mask       = (FRAC_BITS'(1) << u_size_q) - FRAC_BITS'(1);
    v_mask       = (FRAC_BITS'(1) << v_size_q) - FRAC_BITS'(1);
    addr_full    = WORD_W'(u_int & u_mask) | (WORD_W'(v_int & v_mask) << u_size_q);
    tex_raddr    = addr_full[TEX_ADDR_BITS-1:0];
    addr_wrapped = WORD_W'(tex_raddr);
    waddr_ext    = WORD_W'(in_addr);
    tex_waddr    = waddr_ext[TEX_ADDR_BITS-1:0];
  end

  logic draw, tex_we, pal_we, pal_ok;
  logic [5:0] wr_pal;

  assign draw   = accept && (cmd == CMD_DRAW_PIXEL);
  assign tex_we = accept && (cmd == CMD_WRITE_TEXEL);
  assign wr_pal = in_addr[ADDR_W-1:PAL_ENTRY_W];
  assign pal_ok = (32'(wr_pal) < NUM_PALETTES);
  assign pal_we = accept && (cmd == CMD_WRITE_PALETTE) && pal_ok;

  logic [WORD_W-1:0] tex_rdata;

  tsm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TEX_DEPTH),
    .ADDR_W(TEX_ADDR_BITS)
  ) u_tex_ram (
    .clk_i  (clk_i),
    .we_i   (tex_we),
    .waddr_i(tex_waddr),
    .wdata_i(in_wdata),
    .re_i   (draw),
    .raddr_i(tex_raddr),
    .rdata_o(tex_rdata)
  );

  // Stage 1: texel read returns, palette lookup is issued.
  logic              v1_q;
  logic [ADDR_W-1:0] taddr1_q;
  logic [PAL_W-1:0]  pal1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= draw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw) begin
      taddr1_q <= addr_wrapped[ADDR_W-1:0];
      pal1_q   <= pal_q;
    end
  end

  logic [PAL_AW-1:0]     pal_waddr, pal_raddr;
  logic [COLOR_BITS:0]   pal_wdata, pal_rdata;

  assign pal_waddr = PAL_AW'({wr_pal[PAL_W-1:0], in_addr[PAL_ENTRY_W-1:0]});
  assign pal_raddr = PAL_AW'({pal1_q, tex_rdata[PAL_ENTRY_W-1:0]});
  assign pal_wdata = {in_alpha, in_wdata[COLOR_BITS-1:0]};

  tsm_ram #(
    .WIDTH (COLOR_BITS + 1),
    .DEPTH (PAL_DEPTH),
    .ADDR_W(PAL_AW)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(pal_waddr),
    .wdata_i(pal_wdata),
    .re_i   (v1_q),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  // Stage 2: palette read returns, colour and write flag are chosen.
  logic                  v2_q;
  logic [ADDR_W-1:0]     taddr2_q;
  logic [COLOR_BITS-1:0] tex2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      taddr2_q <= taddr1_q;
      tex2_q   <= tex_rdata[COLOR_BITS-1:0];
    end
  end

  logic [COLOR_BITS-1:0] pix_color;
  logic                  pix_write;

  always_comb begin
    pix_color = tex2_q;
    pix_write = 1'b1;
    if (paletted_q) begin
      pix_color = pal_rdata[COLOR_BITS-1:0];
      if (alpha_test_q && !pal_rdata[COLOR_BITS]) begin
        pix_color = '0;
        pix_write = 1'b0;
      end
    end
  end

  // Output queue.
  logic [ENTRY_W-1:0] q_in, q_out;
  logic [LVL_W-1:0]   q_level;
  logic               q_pop;

  assign q_in  = {taddr2_q, pix_write, pix_color};
  assign q_pop = m_axis_tvalid & m_axis_tready;

  tsm_out_fifo #(
    .WIDTH(ENTRY_W)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (v2_q),
    .push_data_i(q_in),
    .pop_i      (q_pop),
    .level_o    (q_level),
    .valid_o    (m_axis_tvalid),
    .data_o     (q_out)
  );

  assign s_axis_tready = ((LVL_W + 2)'(q_level) + (LVL_W + 2)'(v1_q) + (LVL_W + 2)'(v2_q))
                         < (LVL_W + 2)'(OUT_FIFO_DEPTH);
  assign m_axis_tdata  = OUT_W'({q_out[ENTRY_W-1 -: ADDR_W], q_out[COLOR_BITS-1:0]});
  assign m_axis_tuser  = q_out[COLOR_BITS];

endmodule

`default_nettype wire

FILE: design/tsm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read and a write of the same entry in one cycle return the old contents.
`default_nettype none

module tsm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/tsm_out_fifo.sv
// Small output queue that decouples the pixel pipeline from the receiver.
// Depends on tsm_pkg for its depth; entries are opaque packed words.
`default_nettype none

module tsm_out_fifo
  import tsm_pkg::*;
#(
  parameter int WIDTH = 47,
  localparam int DEPTH = OUT_FIFO_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int LVL_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [LVL_W-1:0] level_o,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    level_d  = level_q + LVL_W'(push_i) - LVL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign level_o = level_q;
  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: design/tsm_checker.sv
// Port-level checker for the textured span mapper, attached by bind.
// Depends on tsm_pkg and the assertion macros in textured_span_mapper_defines.svh.
`default_nettype none
`include "textured_span_mapper_defines.svh"

module tsm_checker
  import tsm_pkg::*;
#(
  parameter int COLOR_BITS = 32,
  localparam int OUT_W = ((COLOR_BITS + ADDR_W + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [CMD_W-1:0] s_axis_tuser,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic [0:0]       m_axis_tuser
);

  logic draw_req;

  assign draw_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_DRAW_PIXEL);

  `TSM_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output request dropped while stalled")
  `TSM_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "output payload changed while stalled")
  `TSM_ASSERT_IMPL(a_draw_reaches_out, clk_i, rst_ni, draw_req, ##3 m_axis_tvalid, "draw request did not reach the output queue")
  `TSM_ASSERT_IMPL(a_skip_is_black, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[COLOR_BITS-1:0] == '0, "skipped pixel carries a colour")

endmodule

bind textured_span_mapper tsm_checker #(
  .COLOR_BITS(COLOR_BITS)
) u_tsm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

FILE: tb/textured_span_mapper_test.sv
// Self-checking testbench for textured_span_mapper: a pixel scoreboard tracks the
// stores, coordinates and configuration and predicts every pixel from the requests.
// Depends on tsm_pkg and the textured_span_mapper RTL.
`default_nettype none

module textured_span_mapper_test
  import tsm_pkg::*;
;

  localparam int COLOR_W        = 32;
  localparam int PALETTE_COUNT  = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [3:0] PHASE_U_LOG2 [PHASES] = '{4'd7, 4'd0, 4'd14, 4'd15,
                                                   4'd3, 4'd0, 4'd14, 4'd15};
  localparam logic [3:0] PHASE_V_LOG2 [PHASES] = '{4'd7, 4'd0, 4'd14, 4'd15,
                                                   4'd2, 4'd14, 4'd0, 4'd0};
  localparam logic PHASE_PALETTED [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0,
                                               1'b1, 1'b1, 1'b0, 1'b1};
  localparam logic PHASE_ALPHA    [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0,
                                               1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct {
    cmd_e        cmd;
    logic [13:0] addr;
    logic [31:0] data;
    logic        alpha;
    logic [31:0] u_start;
    logic [31:0] v_start;
    logic [31:0] u_step;
    logic [31:0] v_step;
    logic [2:0]  palette;
  } request_t;

  typedef struct {
    logic [31:0] color;
    logic        write;
    logic [13:0] taddr;
  } pixel_t;

  class pixel_scoreboard;
    logic [31:0] texels [int];
    logic [31:0] pal_color [int];
    logic        pal_alpha [int];
    logic [31:0] u_pos, v_pos, u_inc, v_inc;
    logic [2:0]  pal_sel;
    logic [3:0]  u_log2, v_log2;
    logic        paletted, alpha_test;
    pixel_t      expected_pixels [$];
    int          errors;
    int          checked;

    function new();
      u_pos = '0; v_pos = '0; u_inc = '0; v_inc = '0; pal_sel = '0;
      u_log2 = 4'd7; v_log2 = 4'd7; paletted = 1'b0; alpha_test = 1'b0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [3:0] value);
      case (idx)
        REG_U_SIZE_LOG2: u_log2 = value;
        REG_V_SIZE_LOG2: v_log2 = value;
        REG_PALETTED:    paletted = value[0];
        REG_ALPHA_TEST:  alpha_test = value[0];
        default: ;
      endcase
    endfunction

    function logic [13:0] texel_addr();
      logic [63:0] umask, vmask, pu, pv;
      umask = (64'd1 << u_log2) - 64'd1;
      vmask = ((64'd1 << v_log2) - 64'd1) << u_log2;
      pu = 64'(u_pos >> FRAC_BITS) & umask;
      pv = 64'(v_pos >> (FRAC_BITS - int'(u_log2))) & vmask;
      return 14'(pu | pv);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_request(request_t r);
      pixel_t      px;
      logic [31:0] texel;
      int          slot;
      case (r.cmd)
        CMD_WRITE_TEXEL: texels[r.addr] = r.data;
        CMD_WRITE_PALETTE: begin
          if ((r.addr >> 8) < PALETTE_COUNT) begin
            pal_color[r.addr] = r.data;
            pal_alpha[r.addr] = r.alpha;
          end
        end
        CMD_START_SPAN: begin
          u_pos = r.u_start; v_pos = r.v_start;
          u_inc = r.u_step;  v_inc = r.v_step;
          pal_sel = r.palette;
        end
        default: begin
          px.taddr = texel_addr();
          texel = texels.exists(px.taddr) ? texels[px.taddr] : '0;
          px.write = 1'b1;
          if (paletted) begin
            slot = (int'(pal_sel) % PALETTE_COUNT) * 256 + int'(texel[7:0]);
            px.color = pal_color.exists(slot) ? pal_color[slot] : '0;
            if (alpha_test && !(pal_alpha.exists(slot) && pal_alpha[slot])) begin
              px.write = 1'b0;
              px.color = '0;
            end
          end else begin
            px.color = texel;
          end
          expected_pixels.push_back(px);
          u_pos = u_pos + u_inc;
          v_pos = v_pos + v_inc;
        end
      endcase
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel with none expected: color %h write %b address %h",
               got.color, got.write, got.taddr);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.color !== want.color) begin
        $error("pixel_color: expected %h, got %h", want.color, got.color);
        errors++;
      end
      if (got.write !== want.write) begin
        $error("pixel_write: expected %b, got %b", want.write, got.write);
        errors++;
      end
      if (got.taddr !== want.taddr) begin
        $error("texel_address: expected %h, got %h", want.taddr, got.taddr);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [1:0]        cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic [CMD_W-1:0]  s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  pixel_scoreboard sb = new();
  int  requests_sent  = 0;
  int  quiet_cycles   = 0;
  bit  source_steady  = 1'b0;
  bit  long_hold_done = 1'b0;

  textured_span_mapper DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic request_t random_request(cmd_e c);
    request_t r;
    r.cmd     = c;
    r.addr    = 14'($urandom);
    r.data    = $urandom;
    r.alpha   = 1'($urandom);
    r.u_start = $urandom;
    r.v_start = $urandom;
    r.u_step  = $urandom;
    r.v_step  = $urandom;
    r.palette = 3'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return $urandom_range(0, 32'h00FF_FFFF);
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom_range(0, 32'h0003_FFFF);
      2: return 32'(0 - $urandom_range(0, 32'h0003_FFFF));
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input request_t r);
    int              gap;
    logic [IN_W-1:0] bits;
    gap = source_steady ? 0 : pick_gap();
    bits = '0;
    bits[IN_ADDR_LSB  +: ADDR_W] = r.addr;
    bits[IN_WDATA_LSB +: WORD_W] = r.data;
    bits[IN_ALPHA_LSB]           = r.alpha;
    bits[IN_USTRT_LSB +: WORD_W] = r.u_start;
    bits[IN_VSTRT_LSB +: WORD_W] = r.v_start;
    bits[IN_USTEP_LSB +: WORD_W] = r.u_step;
    bits[IN_VSTEP_LSB +: WORD_W] = r.v_step;
    bits[IN_PSEL_LSB  +: PSEL_W] = r.palette;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= bits;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
    if (!(r.cmd == CMD_WRITE_PALETTE && (r.addr >> 8) >= PALETTE_COUNT)) begin
      requests_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_write(input cmd_e c, input logic [13:0] a, input logic [31:0] d,
                            input logic al);
    request_t r;
    r = random_request(c);
    r.addr = a; r.data = d; r.alpha = al;
    send(r);
  endtask

  task automatic start_span(input logic [31:0] u0, input logic [31:0] v0,
                            input logic [31:0] du, input logic [31:0] dv,
                            input logic [2:0] pal);
    request_t r;
    r = random_request(CMD_START_SPAN);
    r.u_start = u0; r.v_start = v0; r.u_step = du; r.v_step = dv; r.palette = pal;
    send(r);
  endtask

  // Writes whatever the next pixel reads if it has not been written yet.
  task automatic draw_pixel();
    logic [13:0] a;
    logic [10:0] slot;
    a = sb.texel_addr();
    if (!sb.texels.exists(a)) send_write(CMD_WRITE_TEXEL, a, $urandom, 1'($urandom));
    if (sb.paletted) begin
      slot = {sb.pal_sel, sb.texels[a][7:0]};
      if (!sb.pal_color.exists(slot)) begin
        send_write(CMD_WRITE_PALETTE, {3'b000, slot}, $urandom, 1'($urandom));
      end
    end
    send(random_request(CMD_DRAW_PIXEL));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    sb.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [3:0] ul, input logic [3:0] vl,
                           input logic pal, input logic at);
    wait_idle();
    write_reg(REG_U_SIZE_LOG2, ul);
    write_reg(REG_V_SIZE_LOG2, vl);
    write_reg(REG_PALETTED, {3'b000, pal});
    write_reg(REG_ALPHA_TEST, {3'b000, at});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_traffic(input int count);
    int first;
    int n;
    first = requests_sent;
    while (requests_sent - first < count) begin
      source_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 6);
          repeat (n) send_write(CMD_WRITE_TEXEL, 14'($urandom), $urandom, 1'($urandom));
        end
        2: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
              send_write(CMD_WRITE_PALETTE, 14'($urandom), $urandom, 1'($urandom));
            end else begin
              send_write(CMD_WRITE_PALETTE, 14'($urandom_range(0, 2047)), $urandom,
                         1'($urandom));
            end
          end
        end
        3: begin
          // A run of pixels that continues the previous span.
          n = $urandom_range(1, 8);
          repeat (n) draw_pixel();
        end
        default: begin
          start_span(pick_coord(), pick_coord(), pick_step(), pick_step(), 3'($urandom));
          n = $urandom_range(1, 24);
          repeat (n) draw_pixel();
        end
      endcase
    end
    source_steady = 1'b0;
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset configuration, then the special cases.
    send_write(CMD_WRITE_TEXEL, 14'h0000, 32'h0000_0000, 1'b0);
    send_write(CMD_WRITE_TEXEL, 14'h3FFF, 32'hFFFF_FFFF, 1'b1);
    send_write(CMD_WRITE_PALETTE, 14'h0000, 32'hFFFF_FFFF, 1'b1);
    send_write(CMD_WRITE_PALETTE, 14'h07FF, 32'h0000_0000, 1'b0);
    send_write(CMD_WRITE_PALETTE, 14'h0800, 32'hDEAD_BEEF, 1'b1);
    send_write(CMD_WRITE_PALETTE, 14'h3FFF, 32'h1234_5678, 1'b0);
    draw_pixel();
    start_span(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 3'd7);
    draw_pixel();
    draw_pixel();
    configure(4'd7, 4'd7, 1'b1, 1'b1);
    start_span(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 3'd7);
    draw_pixel();
    start_span(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 3'd0);
    draw_pixel();
    draw_pixel();
    configure(4'd15, 4'd15, 1'b0, 1'b0);
    start_span(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 3'd0);
    draw_pixel();
    draw_pixel();
    configure(4'd0, 4'd0, 1'b0, 1'b1);
    start_span(32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 32'h0000_0001, 3'd5);
    draw_pixel();

    for (phase = 0; phase < PHASES; phase++) begin
      configure(PHASE_U_LOG2[phase], PHASE_V_LOG2[phase], PHASE_PALETTED[phase],
                PHASE_ALPHA[phase]);
      random_traffic(PHASE_REQUESTS);
    end
    wait_idle();

    $display("Sent %0d requests and checked %0d pixels over %0d size and mode settings,",
             requests_sent, sb.checked, PHASES + 4);
    $display("including direct, paletted and alpha-tested spans and a long output stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("textured_span_mapper_test passed");
    end else begin
      $display("textured_span_mapper_test failed");
    end
    $finish;
  end

  initial begin
    int sink_gap;
    int steady_left;
    sink_gap = 0;
    steady_left = 0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && sb.checked >= 300 && s_axis_tvalid) begin
        // Long output stall while requests keep coming.
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (steady_left == 0 && $urandom_range(0, 63) == 0) steady_left = $urandom_range(20, 100);
      if (steady_left > 0) begin
        steady_left--;
        m_axis_tready <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.color = m_axis_tdata[COLOR_W-1:0];
      got.taddr = m_axis_tdata[COLOR_W +: ADDR_W];
      got.write = m_axis_tuser[0];
      sb.check_pixel(got);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("textured_span_mapper_test failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/tsm_pkg.sv
design/tsm_ram.sv
design/tsm_out_fifo.sv
design/textured_span_mapper.sv
design/tsm_checker.sv
tb/textured_span_mapper_test.sv
